// File: src/rvdec_pkg.sv
// rvdec_pkg: beat types, opcode and operation codes for the RV32I decoder.
// No dependencies; imported by rvdec_decode, rv32i_instruction_decoder and the testbench.
`timescale 1ns / 1ps

package rvdec_pkg;

  // Input beat: one instruction word and its address
  typedef struct packed {
    logic [31:0] instr_word;
    logic [31:0] instr_address;
  } in_beat_t;

  // Result beat
  typedef struct packed {
    logic [5:0]  op;
    logic [4:0]  dest_reg;
    logic [4:0]  src1_reg;
    logic [4:0]  src2_reg;
    logic [31:0] immediate;
    logic [4:0]  shift_amount;
    logic [31:0] address_out;
  } out_beat_t;

  localparam logic [31:0] HALT_WORD = 32'h0ff0_0513;

  // Major opcodes, bits 6:0
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_OP_IMM = 7'h13;
  localparam logic [6:0] OPC_OP     = 7'h33;

  // funct3 codes
  localparam logic [2:0] F3_0 = 3'd0;
  localparam logic [2:0] F3_1 = 3'd1;
  localparam logic [2:0] F3_2 = 3'd2;
  localparam logic [2:0] F3_3 = 3'd3;
  localparam logic [2:0] F3_4 = 3'd4;
  localparam logic [2:0] F3_5 = 3'd5;
  localparam logic [2:0] F3_6 = 3'd6;
  localparam logic [2:0] F3_7 = 3'd7;

  // Operation numbers
  localparam logic [5:0] OP_INVALID = 6'd0;
  localparam logic [5:0] OP_LUI     = 6'd1;
  localparam logic [5:0] OP_AUIPC   = 6'd2;
  localparam logic [5:0] OP_JAL     = 6'd3;
  localparam logic [5:0] OP_JALR    = 6'd4;
  localparam logic [5:0] OP_BEQ     = 6'd5;
  localparam logic [5:0] OP_BNE     = 6'd6;
  localparam logic [5:0] OP_BLT     = 6'd7;
  localparam logic [5:0] OP_BGE     = 6'd8;
  localparam logic [5:0] OP_BLTU    = 6'd9;
  localparam logic [5:0] OP_BGEU    = 6'd10;
  localparam logic [5:0] OP_LB      = 6'd11;
  localparam logic [5:0] OP_LH      = 6'd12;
  localparam logic [5:0] OP_LW      = 6'd13;
  localparam logic [5:0] OP_LBU     = 6'd14;
  localparam logic [5:0] OP_LHU     = 6'd15;
  localparam logic [5:0] OP_SB      = 6'd16;
  localparam logic [5:0] OP_SH      = 6'd17;
  localparam logic [5:0] OP_SW      = 6'd18;
  localparam logic [5:0] OP_ADDI    = 6'd19;
  localparam logic [5:0] OP_SLTI    = 6'd20;
  localparam logic [5:0] OP_SLTIU   = 6'd21;
  localparam logic [5:0] OP_XORI    = 6'd22;
  localparam logic [5:0] OP_ORI     = 6'd23;
  localparam logic [5:0] OP_ANDI    = 6'd24;
  localparam logic [5:0] OP_SLLI    = 6'd25;
  localparam logic [5:0] OP_SRLI    = 6'd26;
  localparam logic [5:0] OP_SRAI    = 6'd27;
  localparam logic [5:0] OP_ADD     = 6'd28;
  localparam logic [5:0] OP_SUB     = 6'd29;
  localparam logic [5:0] OP_SLL     = 6'd30;
  localparam logic [5:0] OP_SLT     = 6'd31;
  localparam logic [5:0] OP_SLTU    = 6'd32;
  localparam logic [5:0] OP_XOR     = 6'd33;
  localparam logic [5:0] OP_SRL     = 6'd34;
  localparam logic [5:0] OP_SRA     = 6'd35;
  localparam logic [5:0] OP_OR      = 6'd36;
  localparam logic [5:0] OP_AND     = 6'd37;
  localparam logic [5:0] OP_HALT    = 6'd38;

endpackage

// File: src/rv32i_instruction_decoder.sv
// rv32i_instruction_decoder: top level, input register, decode, result register.
// Depends on rvdec_pkg and rvdec_decode.
`timescale 1ns / 1ps

// Channel   Ports                         Handshake
// input     start, busy, in_payload       beat taken when start & !busy
// result    out_valid, out_payload        one-cycle strobe, always taken
//
// Every beat passes from start to out_valid through the input register, then
// through the decoder into the result register.
// A new beat is accepted every cycle; busy is held low, nothing stalls.
// The receiver cannot hold results off, so none is ever needed.
// rst_n (synchronous, active low) clears both valid flags; payload
// registers are not reset.

module rv32i_instruction_decoder
  import rvdec_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_payload,
  output logic      out_valid,
  output out_beat_t out_payload
);

  // input stage
  logic      in_vld_r;
  in_beat_t  in_beat_r;
  // decoder output
  out_beat_t dec_nxt;
  // result stage
  logic      out_vld_r;
  out_beat_t out_beat_r;

  // pipeline never backs up
  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start & ~busy) begin
      in_beat_r <= in_payload;
    end
  end

  rvdec_decode u_decode (
    .beat_i (in_beat_r),
    .beat_o (dec_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_vld_r) begin
      out_beat_r <= dec_nxt;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_payload = out_beat_r;

endmodule

// File: src/rvdec_decode.sv
// rvdec_decode: combinational decode of one RV32I word into a result beat.
// Depends on rvdec_pkg.
`timescale 1ns / 1ps

module rvdec_decode
  import rvdec_pkg::*;
(
  input  in_beat_t  beat_i,
  output out_beat_t beat_o
);

  logic [31:0] w;
  logic [2:0]  f3;
  logic        alt;
  logic [31:0] imm_i, imm_s, imm_b, imm_j, imm_u;
  logic [5:0]  op;
  logic [31:0] imm;
  logic [4:0]  sh;

  assign w   = beat_i.instr_word;
  assign f3  = w[14:12];
  assign alt = w[30];

  assign imm_i = {{20{w[31]}}, w[31:20]};
  assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
  assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  // upper 20 bits kept unshifted, sign-extended from bit 19
  assign imm_u = {{12{w[31]}}, w[31:12]};

  always_comb begin
    op  = OP_INVALID;
    imm = '0;
    sh  = '0;
    unique case (w[6:0])
      OPC_LUI: begin
        op  = OP_LUI;
        imm = imm_u;
      end
      OPC_AUIPC: begin
        op  = OP_AUIPC;
        imm = imm_u;
      end
      OPC_JAL: begin
        op  = OP_JAL;
        imm = imm_j;
      end
      OPC_JALR: begin
        op  = OP_JALR;
        imm = imm_i;
      end
      OPC_BRANCH: begin
        imm = imm_b;
        unique case (f3)
          F3_0:    op = OP_BEQ;
          F3_1:    op = OP_BNE;
          F3_4:    op = OP_BLT;
          F3_5:    op = OP_BGE;
          F3_6:    op = OP_BLTU;
          F3_7:    op = OP_BGEU;
          default: op = OP_INVALID;
        endcase
      end
      OPC_LOAD: begin
        imm = imm_i;
        unique case (f3)
          F3_0:    op = OP_LB;
          F3_1:    op = OP_LH;
          F3_2:    op = OP_LW;
          F3_4:    op = OP_LBU;
          F3_5:    op = OP_LHU;
          default: op = OP_INVALID;
        endcase
      end
      OPC_STORE: begin
        imm = imm_s;
        unique case (f3)
          F3_0:    op = OP_SB;
          F3_1:    op = OP_SH;
          F3_2:    op = OP_SW;
          default: op = OP_INVALID;
        endcase
      end
      OPC_OP_IMM: begin
        imm = imm_i;
        sh  = w[24:20];
        unique case (f3)
          F3_0: op = OP_ADDI;
          F3_1: op = OP_SLLI;
          F3_2: op = OP_SLTI;
          F3_3: op = OP_SLTIU;
          F3_4: op = OP_XORI;
          F3_5: op = alt ? OP_SRAI : OP_SRLI;
          F3_6: op = OP_ORI;
          F3_7: op = OP_ANDI;
          default: op = OP_INVALID;
        endcase
      end
      OPC_OP: begin
        unique case (f3)
          F3_0: op = alt ? OP_SUB : OP_ADD;
          F3_1: op = OP_SLL;
          F3_2: op = OP_SLT;
          F3_3: op = OP_SLTU;
          F3_4: op = OP_XOR;
          F3_5: op = alt ? OP_SRA : OP_SRL;
          F3_6: op = OP_OR;
          F3_7: op = OP_AND;
          default: op = OP_INVALID;
        endcase
      end
      default: op = OP_INVALID;
    endcase

    beat_o.address_out = beat_i.instr_address;
    if (w == HALT_WORD) begin
      beat_o.op           = OP_HALT;
      beat_o.dest_reg     = '0;
      beat_o.src1_reg     = '0;
      beat_o.src2_reg     = '0;
      beat_o.immediate    = '0;
      beat_o.shift_amount = '0;
    end else begin
      beat_o.op           = op;
      beat_o.dest_reg     = w[11:7];
      beat_o.src1_reg     = w[19:15];
      beat_o.src2_reg     = w[24:20];
      // invalid encodings keep the register fields, drop imm and shamt
      beat_o.immediate    = (op == OP_INVALID) ? '0 : imm;
      beat_o.shift_amount = (op == OP_INVALID) ? '0 : sh;
    end
  end

endmodule

// File: sim/rv32i_instruction_decoder_tb.sv
// rv32i_instruction_decoder_tb: self-checking testbench for the RV32I decoder.
// Depends on rvdec_pkg and rv32i_instruction_decoder; directed table, then bursts of
// random instructions, every result beat checked against a hand-typed expectation or an in-bench decoder.
`timescale 1ns / 1ps

module rv32i_instruction_decoder_tb
  import rvdec_pkg::*;
();

  localparam int RANDOM_BEATS   = 1100;
  localparam int MAX_GAP        = 6;    // longest idle gap between sender bursts
  localparam int WATCHDOG_LIMIT = 100;  // cycles with no beat moving either way
  localparam int END_LIMIT      = 64;   // bound on the final drain
  localparam int TAIL_CYCLES    = 6;    // pipeline is two deep; catch any stray beat
  localparam int MAX_REPORTS    = 60;

  // One row of the directed table. Rows with 'known' set carry a hand-typed
  // expectation; the rest are checked against decode_instr.
  typedef struct {
    logic [31:0] word;
    logic [31:0] addr;
    bit          known;
    out_beat_t   want;
  } vec_row_t;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_beat_t  in_payload;
  logic      out_valid;
  out_beat_t out_payload;

  // Travels alongside in_payload so the monitor knows which expectation
  // belongs to the beat it sees accepted.
  bit        row_known;
  out_beat_t row_want;

  out_beat_t pending_decodes[$];
  int        fault_count;
  int        stall_cycles;

  rv32i_instruction_decoder i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_payload  (in_payload),
    .out_valid   (out_valid),
    .out_payload (out_payload)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decoder prediction
  // ---------------------------------------------------------------------------

  // Full decode of one instruction beat. The halt word wins over everything;
  // anything that ends up invalid has its immediate and shift amount cleared
  // but keeps the raw register fields.
  function automatic out_beat_t decode_instr(in_beat_t b);
    logic [31:0] w;
    logic [2:0]  f3;
    logic        alt;
    logic [31:0] i_imm;
    out_beat_t   r;
    w     = b.instr_word;
    f3    = w[14:12];
    alt   = w[30];
    i_imm = {{20{w[31]}}, w[31:20]};
    r     = '0;
    r.address_out = b.instr_address;
    if (w == HALT_WORD) begin
      r.op = OP_HALT;
      return r;
    end
    r.dest_reg = w[11:7];
    r.src1_reg = w[19:15];
    r.src2_reg = w[24:20];
    r.op       = OP_INVALID;
    case (w[6:0])
      // LUI/AUIPC: raw upper 20 bits, sign-extended, not shifted into place
      OPC_LUI: begin
        r.op        = OP_LUI;
        r.immediate = {{12{w[31]}}, w[31:12]};
      end
      OPC_AUIPC: begin
        r.op        = OP_AUIPC;
        r.immediate = {{12{w[31]}}, w[31:12]};
      end
      OPC_JAL: begin
        r.op        = OP_JAL;
        r.immediate = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      end
      // funct3 of JALR is don't-care
      OPC_JALR: begin
        r.op        = OP_JALR;
        r.immediate = i_imm;
      end
      OPC_BRANCH: begin
        r.immediate = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
        case (f3)
          F3_0:    r.op = OP_BEQ;
          F3_1:    r.op = OP_BNE;
          F3_4:    r.op = OP_BLT;
          F3_5:    r.op = OP_BGE;
          F3_6:    r.op = OP_BLTU;
          F3_7:    r.op = OP_BGEU;
          default: r.op = OP_INVALID;
        endcase
      end
      OPC_LOAD: begin
        r.immediate = i_imm;
        case (f3)
          F3_0:    r.op = OP_LB;
          F3_1:    r.op = OP_LH;
          F3_2:    r.op = OP_LW;
          F3_4:    r.op = OP_LBU;
          F3_5:    r.op = OP_LHU;
          default: r.op = OP_INVALID;
        endcase
      end
      OPC_STORE: begin
        r.immediate = {{20{w[31]}}, w[31:25], w[11:7]};
        case (f3)
          F3_0:    r.op = OP_SB;
          F3_1:    r.op = OP_SH;
          F3_2:    r.op = OP_SW;
          default: r.op = OP_INVALID;
        endcase
      end
      // Every funct3 is legal here; shift amount is given for all of them
      OPC_OP_IMM: begin
        r.immediate    = i_imm;
        r.shift_amount = w[24:20];
        case (f3)
          F3_0:    r.op = OP_ADDI;
          F3_1:    r.op = OP_SLLI;
          F3_2:    r.op = OP_SLTI;
          F3_3:    r.op = OP_SLTIU;
          F3_4:    r.op = OP_XORI;
          F3_5:    r.op = alt ? OP_SRAI : OP_SRLI;
          F3_6:    r.op = OP_ORI;
          default: r.op = OP_ANDI;
        endcase
      end
      // Only funct7 bit 30 matters
      OPC_OP: begin
        case (f3)
          F3_0:    r.op = alt ? OP_SUB : OP_ADD;
          F3_1:    r.op = OP_SLL;
          F3_2:    r.op = OP_SLT;
          F3_3:    r.op = OP_SLTU;
          F3_4:    r.op = OP_XOR;
          F3_5:    r.op = alt ? OP_SRA : OP_SRL;
          F3_6:    r.op = OP_OR;
          default: r.op = OP_AND;
        endcase
      end
      default: r.op = OP_INVALID;
    endcase
    if (r.op == OP_INVALID) begin
      r.immediate    = '0;
      r.shift_amount = '0;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic flag_error(input string msg);
    if (fault_count < MAX_REPORTS) $display("ERROR %0t: %s", $time, msg);
    fault_count++;
  endtask

  task automatic compare_beat(input out_beat_t got, input out_beat_t want);
    if (got.op !== want.op)
      flag_error($sformatf("op %0d, want %0d (pc %h)", got.op, want.op, want.address_out));
    if (got.dest_reg !== want.dest_reg)
      flag_error($sformatf("dest_reg %0d, want %0d (pc %h)",
                           got.dest_reg, want.dest_reg, want.address_out));
    if (got.src1_reg !== want.src1_reg)
      flag_error($sformatf("src1_reg %0d, want %0d (pc %h)",
                           got.src1_reg, want.src1_reg, want.address_out));
    if (got.src2_reg !== want.src2_reg)
      flag_error($sformatf("src2_reg %0d, want %0d (pc %h)",
                           got.src2_reg, want.src2_reg, want.address_out));
    if (got.immediate !== want.immediate)
      flag_error($sformatf("immediate %h, want %h (pc %h)",
                           got.immediate, want.immediate, want.address_out));
    if (got.shift_amount !== want.shift_amount)
      flag_error($sformatf("shift_amount %0d, want %0d (pc %h)",
                           got.shift_amount, want.shift_amount, want.address_out));
    if (got.address_out !== want.address_out)
      flag_error($sformatf("address_out %h, want %h", got.address_out, want.address_out));
  endtask

  // Monitor: a beat goes in when start is high and busy low at the edge;
  // out_valid is a one-cycle strobe that is always taken.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && busy === 1'b0)
        pending_decodes.push_back(row_known ? row_want : decode_instr(in_payload));
      if ($isunknown(out_valid)) begin
        flag_error("out_valid unknown after reset");
      end else if (out_valid) begin
        if (pending_decodes.size() == 0)
          flag_error($sformatf("unexpected result beat, op %0d pc %h",
                               out_payload.op, out_payload.address_out));
        else
          compare_beat(out_payload, pending_decodes.pop_front());
      end
    end
  end

  // Watchdog: any cycle in which no beat moves either way counts towards it
  always @(posedge clk) begin
    if ((start && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no beat moved for %0d cycles", WATCHDOG_LIMIT);
        $display("rv32i_instruction_decoder regression: fail");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Drive one beat and wait for the edge that takes it. start stays high on
  // return so back-to-back calls give an unbroken burst.
  task automatic send_instr(input logic [31:0] word, input logic [31:0] addr,
                            input bit known, input out_beat_t want);
    start      <= 1'b1;
    in_payload <= '{instr_word: word, instr_address: addr};
    row_known  <= known;
    row_want   <= want;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  // Sender gap; payload carries rubbish that must be ignored
  task automatic pause(input int cycles);
    start      <= 1'b0;
    in_payload <= {$urandom, $urandom};
    repeat (cycles) @(posedge clk);
  endtask

  task automatic drain();
    while (pending_decodes.size() != 0) @(posedge clk);
  endtask

  function automatic vec_row_t known_row(logic [31:0] word, logic [31:0] addr,
                                         logic [5:0] op, logic [4:0] rd, logic [4:0] rs1,
                                         logic [4:0] rs2, logic [31:0] imm);
    vec_row_t row;
    row.word = word;
    row.addr = addr;
    row.known = 1'b1;
    row.want = '{op: op, dest_reg: rd, src1_reg: rs1, src2_reg: rs2, immediate: imm,
                 shift_amount: 5'd0, address_out: addr};
    return row;
  endfunction

  function automatic vec_row_t predicted_row(logic [31:0] word, logic [31:0] addr);
    vec_row_t row;
    row.word = word;
    row.addr = addr;
    row.known = 1'b0;
    row.want = '0;
    return row;
  endfunction

  // Mostly well-formed instructions with random content; a slice with an
  // illegal funct3, some raw noise, and the halt word and its neighbours.
  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    int          pick;
    bit          broken;
    logic [2:0]  br_ok [6];
    logic [2:0]  br_bad [2];
    logic [2:0]  ld_ok [5];
    logic [2:0]  ld_bad [3];
    br_ok  = '{F3_0, F3_1, F3_4, F3_5, F3_6, F3_7};
    br_bad = '{F3_2, F3_3};
    ld_ok  = '{F3_0, F3_1, F3_2, F3_4, F3_5};
    ld_bad = '{F3_3, F3_6, F3_7};
    w      = $urandom;
    pick   = $urandom_range(0, 99);
    broken = (pick < 20);
    if (pick < 3) return HALT_WORD;
    if (pick < 6) return HALT_WORD ^ (32'd1 << $urandom_range(0, 31));
    if (pick < 10) return w;
    case ($urandom_range(0, 8))
      0: w[6:0] = OPC_LUI;
      1: w[6:0] = OPC_AUIPC;
      2: w[6:0] = OPC_JAL;
      3: w[6:0] = OPC_JALR;
      4: begin
        w[6:0]   = OPC_BRANCH;
        w[14:12] = broken ? br_bad[$urandom_range(0, 1)] : br_ok[$urandom_range(0, 5)];
      end
      5: begin
        w[6:0]   = OPC_LOAD;
        w[14:12] = broken ? ld_bad[$urandom_range(0, 2)] : ld_ok[$urandom_range(0, 4)];
      end
      6: begin
        w[6:0]   = OPC_STORE;
        w[14:12] = broken ? F3_3 + 3'($urandom_range(0, 4)) : 3'($urandom_range(0, 2));
      end
      7: w[6:0] = OPC_OP_IMM;
      default: w[6:0] = OPC_OP;
    endcase
    return w;
  endfunction

  initial begin
    vec_row_t    dir_rows[$];
    int          sent;
    int          burst;
    int          k;
    int          pick;
    bit          drained;
    logic [31:0] addr;

    rst_n       = 1'b0;
    start       = 1'b0;
    in_payload  = '0;
    row_known   = 1'b0;
    row_want    = '0;
    fault_count = 0;
    stall_cycles = 0;

    dir_rows = '{
      // halt marker straight out of reset, then all-zero, all-ones, LUI and AUIPC words
      known_row(HALT_WORD, 32'h0000_0000, OP_HALT, 5'd0, 5'd0, 5'd0, 32'h0),
      known_row(32'h0000_0000, 32'hFFFF_FFFF, OP_INVALID, 5'd0, 5'd0, 5'd0, 32'h0),
      known_row(32'hFFFF_FFFF, 32'h0000_0000, OP_INVALID, 5'd31, 5'd31, 5'd31, 32'h0),
      known_row(32'hFFFF_FFB7, 32'h1234_5678, OP_LUI, 5'd31, 5'd31, 5'd31, 32'hFFFF_FFFF),
      known_row(32'h8000_0017, 32'hFFFF_FFFC, OP_AUIPC, 5'd0, 5'd0, 5'd0, 32'hFFF8_0000),
      // branch, load and store with illegal funct3, then halt at the top address
      known_row(32'h0000_2063, 32'h0000_0004, OP_INVALID, 5'd0, 5'd0, 5'd0, 32'h0),
      known_row(32'h0000_3063, 32'h0000_0008, OP_INVALID, 5'd0, 5'd0, 5'd0, 32'h0),
      known_row(32'h0000_3003, 32'h0000_000C, OP_INVALID, 5'd0, 5'd0, 5'd0, 32'h0),
      known_row(32'h0000_7003, 32'h0000_0010, OP_INVALID, 5'd0, 5'd0, 5'd0, 32'h0),
      known_row(32'h0000_3023, 32'h0000_0014, OP_INVALID, 5'd0, 5'd0, 5'd0, 32'h0),
      known_row(32'hFFFF_F0A3, 32'h0000_0018, OP_INVALID, 5'd1, 5'd31, 5'd31, 32'h0),
      known_row(HALT_WORD, 32'hFFFF_FFFF, OP_HALT, 5'd0, 5'd0, 5'd0, 32'h0),
      // near misses of the halt word
      predicted_row(32'h8FF0_0513, 32'h0000_0020),
      predicted_row(32'h0FF0_0512, 32'h0000_0024),
      // jump and branch offsets at both extremes, JALR with a nonzero funct3, then load and store
      predicted_row(32'h8000_006F, 32'h0000_0028),
      predicted_row(32'h7FFF_F0EF, 32'h0000_002C),
      predicted_row(32'hFFF0_F0E7, 32'h0000_0030),
      predicted_row(32'h8000_0063, 32'h0000_0034),
      predicted_row(32'h7E0F_FFE3, 32'h0000_0038),
      predicted_row(32'h8000_2003, 32'h0000_003C),
      predicted_row(32'hFE00_2FA3, 32'h0000_0040),
      // funct7: bit 30 picks SRAI/SUB/SRA, SLLI and the other bits ignore it
      predicted_row(32'h41F0_5013, 32'h0000_0044),
      predicted_row(32'h4000_1013, 32'h0000_0048),
      predicted_row(32'h4000_0033, 32'h0000_004C),
      predicted_row(32'hBE00_0033, 32'h0000_0050),
      predicted_row(32'h4000_5033, 32'h0000_0054)
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed table: mostly back to back, with the odd short gap
    foreach (dir_rows[i]) begin
      send_instr(dir_rows[i].word, dir_rows[i].addr, dir_rows[i].known, dir_rows[i].want);
      if ($urandom_range(0, 3) == 0) pause($urandom_range(1, 3));
    end
    // let the pipe empty completely before the random part
    pause(1);
    drain();

    // Random bursts; a quarter of bursts run straight into the next one
    sent    = 0;
    drained = 1'b0;
    while (sent < RANDOM_BEATS) begin
      burst = $urandom_range(1, 40);
      for (k = 0; k < burst && sent < RANDOM_BEATS; k++) begin
        pick = $urandom_range(0, 19);
        addr = (pick == 0) ? 32'h0000_0000 : (pick == 1) ? 32'hFFFF_FFFF : $urandom;
        send_instr(random_instr(), addr, 1'b0, '0);
        sent++;
      end
      if ($urandom_range(0, 3) != 0) pause($urandom_range(1, MAX_GAP));
      if (!drained && sent >= RANDOM_BEATS / 2) begin
        pause(1);
        drain();
        drained = 1'b1;
      end
    end

    // Wind down: stop sending, wait for the last beats, then a short tail
    pause(1);
    for (k = 0; k < END_LIMIT && pending_decodes.size() != 0; k++) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_decodes.size() != 0)
      flag_error($sformatf("%0d result beats never arrived", pending_decodes.size()));

    // decide away from the active edge so the monitor has finished
    @(negedge clk);
    if (fault_count == 0) begin
      $display("rv32i_instruction_decoder regression: pass");
    end else begin
      $display("rv32i_instruction_decoder regression: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
src/rvdec_pkg.sv
src/rvdec_decode.sv
src/rv32i_instruction_decoder.sv
sim/rv32i_instruction_decoder_tb.sv
